[sv/afd_pkg.sv]
`timescale 1ns / 1ps
package afd_pkg;

    localparam logic [2:0] REG_MIN_SCORE       = 3'd0;
    localparam logic [2:0] REG_CLASS_COUNT     = 3'd1;
    localparam logic [2:0] REG_NET_WIDTH       = 3'd2;
    localparam logic [2:0] REG_NET_HEIGHT      = 3'd3;
    localparam logic [2:0] REG_SCALE_X         = 3'd4;
    localparam logic [2:0] REG_SCALE_Y         = 3'd5;
    localparam logic [2:0] REG_BOX_LIMIT       = 3'd6;

    localparam logic signed [31:0] LOG2E_Q16 = 32'sd94548;
    localparam logic signed [31:0] EXP_BIAS  = 32'sd1073741824;
    localparam int EDGE_MAX = 1048575;
    localparam int EDGE_MIN = -1048576;

    typedef struct packed {
        logic [10:0] min_score;
        logic [7:0]  class_count;
        logic [11:0] net_width;
        logic [11:0] net_height;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [15:0] box_limit;
    } t_cfg;

    typedef struct packed {
        logic               box;
        logic               frame_end;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dw;
        logic signed [15:0] dh;
        logic [8:0]         cell_x;
        logic [8:0]         cell_y;
        logic [1:0]         level;
        logic [10:0]        score;
        logic [6:0]         label;
    } t_job;

    typedef struct packed {
        logic               box_valid;
        logic signed [20:0] left;
        logic signed [20:0] top;
        logic signed [20:0] right;
        logic signed [20:0] bottom;
        logic [10:0]        score;
        logic [6:0]         class_label;
        logic               frame_end;
    } t_res;

endpackage

[sv/afd_fifo.sv]
`timescale 1ns / 1ps
module afd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end
endmodule

[sv/afd_front.sv]
`timescale 1ns / 1ps
module afd_front import afd_pkg::*; #(
    parameter int MAX_CLASSES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_accept,
    input  logic signed [15:0] i_value,
    input  logic               i_frame_last,
    output logic               o_job_push,
    output t_job               o_job
);
    logic [8:0]         r_pos;
    logic signed [15:0] r_fld [5];
    logic signed [15:0] r_best;
    logic [6:0]         r_label;
    logic [8:0]         r_cx, r_cy;
    logic [1:0]         r_lvl;
    logic [16:0]        r_cnt;
    logic               r_halt;

    logic [8:0]         w_cc;
    logic [8:0]         w_c;
    logic               w_row_end, w_upd, w_keep;
    logic signed [15:0] w_best;
    logic [6:0]         w_label;
    logic signed [31:0] w_prod;
    logic [10:0]        w_score;
    logic [11:0]        w_gx, w_gy, w_gx_raw, w_gy_raw;
    logic [16:0]        w_cnt_inc;

    always_comb begin
        if (i_cfg.class_count == 8'd0) begin
            w_cc = 9'd1;
        end else if (int'(i_cfg.class_count) > MAX_CLASSES) begin
            w_cc = 9'(MAX_CLASSES);
        end else begin
            w_cc = {1'b0, i_cfg.class_count};
        end
    end

    assign w_row_end = ({1'b0, r_pos} >= (10'd4 + {1'b0, w_cc}));
    assign w_c       = r_pos - 9'd5;
    assign w_upd     = (r_pos >= 9'd5) && ((w_c == 9'd0) || (i_value > r_best));
    assign w_best    = w_upd ? i_value : r_best;
    assign w_label   = w_upd ? w_c[6:0] : r_label;
    assign w_prod    = r_fld[4] * w_best;

    assign w_keep = w_row_end && !r_halt
        && ($signed({r_fld[4][15], r_fld[4]}) >= $signed({6'b0, i_cfg.min_score}))
        && !w_prod[31]
        && (w_prod >= $signed({11'b0, i_cfg.min_score, 10'b0}));

    assign w_score   = (w_prod[31:10] > 22'd1024) ? 11'd1024 : w_prod[20:10];
    assign w_cnt_inc = r_cnt + 17'd1;

    // cells per line and lines for this stride, never below one
    assign w_gx_raw = i_cfg.net_width >> (3'd3 + {1'b0, r_lvl});
    assign w_gy_raw = i_cfg.net_height >> (3'd3 + {1'b0, r_lvl});
    assign w_gx     = (w_gx_raw == '0) ? 12'd1 : w_gx_raw;
    assign w_gy     = (w_gy_raw == '0) ? 12'd1 : w_gy_raw;

    assign o_job_push      = i_accept && (w_keep || i_frame_last);
    assign o_job.box       = w_keep;
    assign o_job.frame_end = i_frame_last;
    assign o_job.dx        = r_fld[0];
    assign o_job.dy        = r_fld[1];
    assign o_job.dw        = r_fld[2];
    assign o_job.dh        = r_fld[3];
    assign o_job.cell_x    = r_cx;
    assign o_job.cell_y    = r_cy;
    assign o_job.level     = r_lvl;
    assign o_job.score     = w_score;
    assign o_job.label     = w_label;

    always_ff @(posedge i_clk) begin
        if (i_accept && r_pos < 9'd5) begin
            r_fld[r_pos[2:0]] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_best  <= '0;
            r_label <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_lvl   <= '0;
            r_cnt   <= '0;
            r_halt  <= 1'b0;
        end else if (i_accept) begin
            if (i_frame_last) begin
                r_pos   <= '0;
                r_best  <= '0;
                r_label <= '0;
                r_cx    <= '0;
                r_cy    <= '0;
                r_lvl   <= '0;
                r_cnt   <= '0;
                r_halt  <= 1'b0;
            end else begin
                r_best  <= w_best;
                r_label <= w_label;
                if (w_row_end) begin
                    r_pos <= '0;
                    if (w_keep) begin
                        r_cnt <= w_cnt_inc;
                        if (w_cnt_inc > {1'b0, i_cfg.box_limit}) begin
                            r_halt <= 1'b1;
                        end
                    end
                    // advance the walk, wrapping after the coarsest stride
                    if ({3'b0, r_cx} + 12'd1 >= w_gx) begin
                        r_cx <= '0;
                        if ({3'b0, r_cy} + 12'd1 >= w_gy) begin
                            r_cy  <= '0;
                            r_lvl <= (r_lvl >= 2'd2) ? 2'd0 : r_lvl + 2'd1;
                        end else begin
                            r_cy <= r_cy + 9'd1;
                        end
                    end else begin
                        r_cx <= r_cx + 9'd1;
                    end
                end else begin
                    r_pos <= r_pos + 9'd1;
                end
            end
        end
    end
endmodule

[sv/afd_back.sv]
`timescale 1ns / 1ps
module afd_back import afd_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_job_empty,
    input  t_job i_job,
    output logic o_job_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);
    localparam int IW = $clog2(EXP_TABLE_DEPTH);
    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_EXPU = 4'd1;
    localparam logic [3:0] ST_IDX  = 4'd2;
    localparam logic [3:0] ST_ROM  = 4'd3;
    localparam logic [3:0] ST_HALF = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    // 2^(i/depth) in Q.16 by a fixed-point series, evaluated at elaboration
    function automatic logic [16:0] exp_entry(input int unsigned idx);
        logic [63:0] x, s, t;
        int unsigned K;
        x = (64'(idx) * LN2_Q30) / 64'(EXP_TABLE_DEPTH);
        s = 64'd1 << 30;
        t = 64'd1 << 30;
        for (K = 1; K <= 20; K++) begin
            t = ((t * x) >> 30) / 64'(K);
            s = s + t;
        end
        return 17'((s + (64'd1 << 13)) >> 14);
    endfunction

    logic [16:0] w_rom [EXP_TABLE_DEPTH];

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [16:0] ENTRY = exp_entry(g);
        assign w_rom[g] = ENTRY;
    end

    logic [3:0]         r_st;
    t_job               r_job;
    logic               r_dim, r_side;
    logic [30:0]        r_u;
    logic [4:0]         r_n;
    logic [IW-1:0]      r_idx;
    logic [16:0]        r_mant;
    logic [31:0]        r_half;
    logic signed [33:0] r_ctr, r_a, r_phi;
    logic [32:0]        r_plo;
    logic signed [20:0] r_left, r_top, r_right, r_bottom;

    logic signed [15:0] w_d, w_d0;
    logic signed [13:0] w_dc;
    logic signed [31:0] w_u;
    logic [38:0]        w_idx_full;
    logic [27:0]        w_e;
    logic [8:0]         w_cell;
    logic signed [33:0] w_c;
    logic [15:0]        w_scale;
    logic signed [50:0] w_full, w_sh;
    logic signed [20:0] w_edge;

    assign w_d  = r_dim ? r_job.dh : r_job.dw;
    assign w_d0 = r_dim ? r_job.dy : r_job.dx;
    assign w_cell  = r_dim ? r_job.cell_y : r_job.cell_x;
    assign w_scale = r_dim ? i_cfg.scale_y : i_cfg.scale_x;

    always_comb begin
        if (w_d < -16'sd8192) begin
            w_dc = -14'sd8192;
        end else if (w_d > 16'sd8191) begin
            w_dc = 14'sd8191;
        end else begin
            w_dc = w_d[13:0];
        end
    end

    assign w_u        = 32'(w_dc) * LOG2E_Q16 + EXP_BIAS;
    assign w_idx_full = 39'(r_u[25:0]) * 39'(EXP_TABLE_DEPTH);
    assign w_e        = (r_n >= 5'd16) ? (28'(r_mant) << (r_n - 5'd16))
                                       : (28'(r_mant) >> (5'd16 - r_n));
    assign w_c = 34'(w_d0) + $signed({15'b0, w_cell, 10'b0});

    assign w_full = (51'(r_phi) <<< 17) + $signed({18'b0, r_plo});
    assign w_sh   = w_full >>> 24;

    always_comb begin
        if (w_sh > 51'(EDGE_MAX)) begin
            w_edge = 21'(EDGE_MAX);
        end else if (w_sh < 51'(EDGE_MIN)) begin
            w_edge = 21'(EDGE_MIN);
        end else begin
            w_edge = w_sh[20:0];
        end
    end

    assign o_job_pop  = (r_st == ST_IDLE) && !i_job_empty;
    assign o_res_push = (r_st == ST_OUT) && !i_res_full;

    always_comb begin
        o_res             = '0;
        o_res.frame_end   = r_job.frame_end;
        if (r_job.box) begin
            o_res.box_valid   = 1'b1;
            o_res.left        = r_left;
            o_res.top         = r_top;
            o_res.right       = r_right;
            o_res.bottom      = r_bottom;
            o_res.score       = r_job.score;
            o_res.class_label = r_job.label;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_job <= i_job;
            end
            ST_EXPU: begin
                r_u <= w_u[30:0];
            end
            ST_IDX: begin
                r_n   <= r_u[30:26];
                r_idx <= w_idx_full[26 +: IW];
            end
            ST_ROM: begin
                r_mant <= w_rom[r_idx];
            end
            ST_HALF: begin
                r_half <= 32'(w_e) << (3'd2 + 3'(r_job.level));
                r_ctr  <= w_c <<< (4'd9 + 4'(r_job.level));
            end
            ST_SUM: begin
                r_a <= r_side ? r_ctr + $signed({2'b0, r_half})
                              : r_ctr - $signed({2'b0, r_half});
            end
            ST_MUL: begin
                r_plo <= 33'(r_a[16:0]) * 33'(w_scale);
                r_phi <= $signed(r_a[33:17]) * $signed({1'b0, w_scale});
            end
            ST_FIN: begin
                case ({r_dim, r_side})
                    2'b00:   r_left   <= w_edge;
                    2'b01:   r_right  <= w_edge;
                    2'b10:   r_top    <= w_edge;
                    default: r_bottom <= w_edge;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_dim  <= 1'b0;
            r_side <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_dim  <= 1'b0;
                        r_side <= 1'b0;
                        r_st   <= i_job.box ? ST_EXPU : ST_OUT;
                    end
                end
                ST_EXPU: r_st <= ST_IDX;
                ST_IDX:  r_st <= ST_ROM;
                ST_ROM:  r_st <= ST_HALF;
                ST_HALF: r_st <= ST_SUM;
                ST_SUM:  r_st <= ST_MUL;
                ST_MUL:  r_st <= ST_FIN;
                ST_FIN: begin
                    if (!r_side) begin
                        r_side <= 1'b1;
                        r_st   <= ST_SUM;
                    end else if (!r_dim) begin
                        r_dim  <= 1'b1;
                        r_side <= 1'b0;
                        r_st   <= ST_EXPU;
                    end else begin
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_res_full) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

[sv/anchor_free_detection_decode.sv]
`timescale 1ns / 1ps
// Streaming box decoder for an anchor-free detector head.
// Input channel: one prediction element per transfer on i_value, taken when
// push is high and full is low; i_frame_last marks the frame's last element.
// Result channel: a queue read side; while empty is low the oldest result is
// on the o_ ports and pop takes it. A result comes for each kept anchor; the
// frame's last element gives one with o_frame_end high (zero box if unkept).
// Configuration: write i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready
// is always high. Write only while the block is idle.
// Elements are classified at one per cycle while full is low. The decoder
// takes one job at a time: a kept box runs two dimensions, each an exp table
// lookup and a low and a high edge through a shared scale multiplier; a bare
// frame end goes straight out. A four-entry job queue between classifier and
// decoder absorbs bursts of kept rows; push stalls (full) once it fills.
// Reset restores the register defaults and clears walk state; no sweep.
// A stalled result side fills the two-entry result queue, then holds the
// decoder, then the job queue, then the input.
module anchor_free_detection_decode import afd_pkg::*; #(
    parameter int MAX_CLASSES     = 128,
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_value,
    input  logic               i_frame_last,
    output logic               empty,
    input  logic               pop,
    output logic               o_box_valid,
    output logic signed [20:0] o_left,
    output logic signed [20:0] o_top,
    output logic signed [20:0] o_right,
    output logic signed [20:0] o_bottom,
    output logic [10:0]        o_score,
    output logic [6:0]         o_class_label,
    output logic               o_frame_end,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    t_cfg r_cfg;
    logic w_accept, w_job_push, w_job_full, w_job_empty, w_job_pop;
    logic w_res_push, w_res_full;
    t_job w_job_in, w_job_out;
    t_res w_res_in, w_res_out;
    logic [$bits(t_job)-1:0] w_job_bits;
    logic [$bits(t_res)-1:0] w_res_bits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_score       <= 11'd256;
            r_cfg.class_count     <= 8'd80;
            r_cfg.net_width       <= 12'd640;
            r_cfg.net_height      <= 12'd640;
            r_cfg.scale_x         <= 16'd4096;
            r_cfg.scale_y         <= 16'd4096;
            r_cfg.box_limit       <= 16'd30000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MIN_SCORE:       r_cfg.min_score       <= i_cfg_data[10:0];
                REG_CLASS_COUNT:     r_cfg.class_count     <= i_cfg_data[7:0];
                REG_NET_WIDTH:       r_cfg.net_width       <= i_cfg_data[11:0];
                REG_NET_HEIGHT:      r_cfg.net_height      <= i_cfg_data[11:0];
                REG_SCALE_X:         r_cfg.scale_x         <= i_cfg_data;
                REG_SCALE_Y:         r_cfg.scale_y         <= i_cfg_data;
                REG_BOX_LIMIT:       r_cfg.box_limit       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign full     = w_job_full;
    assign w_accept = push & ~w_job_full;

    afd_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_value      (i_value),
        .i_frame_last (i_frame_last),
        .o_job_push   (w_job_push),
        .o_job        (w_job_in)
    );

    afd_fifo #(.WIDTH($bits(t_job)), .DEPTH(4)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_bits),
        .o_empty (w_job_empty)
    );

    assign w_job_out = t_job'(w_job_bits);

    afd_back #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    afd_fifo #(.WIDTH($bits(t_res)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_bits),
        .o_empty (empty)
    );

    assign w_res_out     = t_res'(w_res_bits);
    assign o_box_valid   = w_res_out.box_valid;
    assign o_left        = w_res_out.left;
    assign o_top         = w_res_out.top;
    assign o_right       = w_res_out.right;
    assign o_bottom      = w_res_out.bottom;
    assign o_score       = w_res_out.score;
    assign o_class_label = w_res_out.class_label;
    assign o_frame_end   = w_res_out.frame_end;

    a_job_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_push |-> !w_job_full)
        else $error("job written into a full queue");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result written into a full queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_frame_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame_last) |-> w_job_push)
        else $error("frame end transfer produced no job");
endmodule

[bench/afd_box_checker.sv]
`timescale 1ns / 1ps
module afd_box_checker import afd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [15:0] i_value,
    input  logic               i_frame_last,
    input  logic               empty,
    input  logic               pop,
    input  logic               o_box_valid,
    input  logic signed [20:0] o_left,
    input  logic signed [20:0] o_top,
    input  logic signed [20:0] o_right,
    input  logic signed [20:0] o_bottom,
    input  logic [10:0]        o_score,
    input  logic [6:0]         o_class_label,
    input  logic               o_frame_end,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int MAX_CLS   = 128;
    localparam int EXP_DEPTH = 1024;

    t_cfg    cfg;
    t_res    box_q[$];
    longint  pow2_tbl[EXP_DEPTH];

    // walk and row state
    int      elem_pos;
    longint  row_val[5];
    longint  top_score;
    int      top_label;
    int      gx, gy, level;
    int      boxes;
    bit      halted;

    initial begin
        longint unsigned x, sum, term;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            x = (longint'(i) * 64'd744261118) / EXP_DEPTH;
            sum = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * x) >> 30) / k;
                sum += term;
            end
            pow2_tbl[i] = longint'((sum + (64'd1 << 13)) >> 14);
        end
    end

    function automatic longint exp_size(longint d);
        longint u, idx, mant;
        int     n;
        if (d < -8192) d = -8192;
        if (d > 8191) d = 8191;
        u = d * longint'(LOG2E_Q16) + longint'(EXP_BIAS);
        n = int'(u >>> 26);
        idx = ((u & 64'h3FF_FFFF) * EXP_DEPTH) >>> 26;
        mant = pow2_tbl[idx];
        return (n >= 16) ? (mant << (n - 16)) : (mant >> (16 - n));
    endfunction

    function automatic logic signed [20:0] edge_px(longint q, longint s);
        longint v;
        v = (q * s) >>> 24;
        if (v > EDGE_MAX) v = EDGE_MAX;
        if (v < EDGE_MIN) v = EDGE_MIN;
        return v[20:0];
    endfunction

    function automatic int cells(int net, int lvl);
        int g;
        g = net >> (3 + lvl);
        return (g == 0) ? 1 : g;
    endfunction

    task automatic clear_walk();
        elem_pos = 0;
        foreach (row_val[i]) row_val[i] = 0;
        top_score = 0;
        top_label = 0;
        gx = 0;
        gy = 0;
        level = 0;
        boxes = 0;
        halted = 0;
    endtask

    // close a row: decide, decode, advance the cell
    task automatic close_row(output bit kept, output t_res r);
        longint obj, prod, stride, cxq, cyq, hw, hh, sc;
        obj = row_val[4];
        kept = 0;
        r = '0;
        prod = 0;
        if (!halted && obj >= longint'(cfg.min_score)) begin
            prod = obj * top_score;
            kept = prod >= 0 && prod >= longint'(cfg.min_score) * 1024;
        end
        if (kept) begin
            stride = longint'(8) << level;
            cxq = (row_val[0] + longint'(gx) * 1024) * stride * 64;
            cyq = (row_val[1] + longint'(gy) * 1024) * stride * 64;
            hw = exp_size(row_val[2]) * (stride / 2);
            hh = exp_size(row_val[3]) * (stride / 2);
            sc = prod >>> 10;
            if (sc > 1024) sc = 1024;
            r.box_valid   = 1'b1;
            r.left        = edge_px(cxq - hw, cfg.scale_x);
            r.top         = edge_px(cyq - hh, cfg.scale_y);
            r.right       = edge_px(cxq + hw, cfg.scale_x);
            r.bottom      = edge_px(cyq + hh, cfg.scale_y);
            r.score       = sc[10:0];
            r.class_label = top_label[6:0];
            boxes++;
            if (boxes > cfg.box_limit) halted = 1;
        end
        gx++;
        if (gx >= cells(cfg.net_width, level)) begin
            gx = 0;
            gy++;
            if (gy >= cells(cfg.net_height, level)) begin
                gy = 0;
                level = (level >= 2) ? 0 : level + 1;
            end
        end
    endtask

    task automatic take_element(longint v, bit last);
        int   cc;
        bit   kept;
        t_res r;
        cc = cfg.class_count;
        if (cc < 1) cc = 1;
        if (cc > MAX_CLS) cc = MAX_CLS;
        if (elem_pos < 5) begin
            row_val[elem_pos] = v;
        end else if (elem_pos == 5 || v > top_score) begin
            top_score = v;
            top_label = elem_pos - 5;
        end
        kept = 0;
        r = '0;
        if (elem_pos >= 4 + cc) begin
            close_row(kept, r);
            elem_pos = 0;
        end else begin
            elem_pos++;
        end
        if (last) begin
            r.frame_end = 1'b1;
            box_q.insert(box_q.size(), r);
            clear_walk();
        end else if (kept) begin
            box_q.insert(box_q.size(), r);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want, got;
        if (!i_rst_n) begin
            cfg.min_score       <= 11'd256;
            cfg.class_count     <= 8'd80;
            cfg.net_width       <= 12'd640;
            cfg.net_height      <= 12'd640;
            cfg.scale_x         <= 16'd4096;
            cfg.scale_y         <= 16'd4096;
            cfg.box_limit       <= 16'd30000;
            clear_walk();
            box_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MIN_SCORE:       cfg.min_score       <= i_cfg_data[10:0];
                    REG_CLASS_COUNT:     cfg.class_count     <= i_cfg_data[7:0];
                    REG_NET_WIDTH:       cfg.net_width       <= i_cfg_data[11:0];
                    REG_NET_HEIGHT:      cfg.net_height      <= i_cfg_data[11:0];
                    REG_SCALE_X:         cfg.scale_x         <= i_cfg_data;
                    REG_SCALE_Y:         cfg.scale_y         <= i_cfg_data;
                    REG_BOX_LIMIT:       cfg.box_limit       <= i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                got = '{o_box_valid, o_left, o_top, o_right, o_bottom,
                        o_score, o_class_label, o_frame_end};
                if (box_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result %p", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = box_q.pop_front();
                    if (got.box_valid !== want.box_valid || got.left !== want.left ||
                        got.top !== want.top || got.right !== want.right ||
                        got.bottom !== want.bottom || got.score !== want.score ||
                        got.class_label !== want.class_label ||
                        got.frame_end !== want.frame_end) begin
                        if (o_errors < 10)
                            $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (push && !full)
                take_element(longint'(i_value), i_frame_last);
        end
        o_pending <= box_q.size();
    end

endmodule

[bench/anchor_free_detection_decode_test.sv]
`timescale 1ns / 1ps
module anchor_free_detection_decode_test;
    import afd_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] i_value = '0;
    logic               i_frame_last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic               o_box_valid;
    logic signed [20:0] o_left, o_top, o_right, o_bottom;
    logic [10:0]        o_score;
    logic [6:0]         o_class_label;
    logic               o_frame_end;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    int                 mismatches, pending;

    int  n_classes = 80;
    int  elements_sent = 0;
    bit  calm = 0;
    bit  hold_request = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    anchor_free_detection_decode u_top (.*);

    afd_box_checker u_check (
        .i_clk, .i_rst_n, .push, .full, .i_value, .i_frame_last, .empty, .pop,
        .o_box_valid, .o_left, .o_top, .o_right, .o_bottom, .o_score,
        .o_class_label, .o_frame_end, .i_cfg_valid, .o_cfg_ready, .i_cfg_index,
        .i_cfg_data, .o_errors(mismatches), .o_pending(pending)
    );

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_CLASS_COUNT) begin
            n_classes = data[7:0];
            if (n_classes < 1) n_classes = 1;
            if (n_classes > 128) n_classes = 128;
        end
    endtask

    task automatic send(logic signed [15:0] v, bit last);
        push         <= 1'b1;
        i_value      <= v;
        i_frame_last <= last;
        do @(posedge i_clk); while (full);
        elements_sent++;
        if (!calm && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // drop push and wait for the block to drain
    task automatic settle();
        push <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick(int e);
        if ($urandom_range(0, 19) == 0) return 16'($urandom);
        case (e)
            0, 1:    return 16'($urandom_range(0, 2048) - 1024);
            2, 3:    return 16'($urandom_range(0, 6144) - 3072);
            4:       return 16'($urandom_range(0, 1400));
            default: return 16'($urandom_range(0, 1200) - 100);
        endcase
    endfunction

    task automatic run_frame(int rows, bit broken);
        int width, cut;
        width = 5 + n_classes;
        if (rows * width > 400) rows = 1;
        cut = $urandom_range(0, width - 1);
        for (int r = 0; r < rows; r++)
            for (int e = 0; e < width; e++) begin
                if (broken && r == rows - 1 && e == cut) begin
                    send(pick(e), 1'b1);
                    return;
                end
                send(pick(e), r == rows - 1 && e == width - 1);
            end
    endtask

    task automatic random_setup();
        int sel;
        sel = $urandom_range(0, 19);
        write_reg(REG_MIN_SCORE, (sel == 0) ? 16'($urandom_range(0, 2047)) :
                                 16'($urandom_range(0, 600)));
        write_reg(REG_CLASS_COUNT, (sel == 1) ? 16'($urandom_range(0, 255)) :
                                   16'($urandom_range(0, 6)));
        write_reg(REG_NET_WIDTH, (sel == 2) ? 16'($urandom_range(0, 4095)) :
                                 16'(32 * $urandom_range(1, 8)));
        write_reg(REG_NET_HEIGHT, (sel == 3) ? 16'($urandom_range(0, 4095)) :
                                  16'(32 * $urandom_range(1, 8)));
        write_reg(REG_SCALE_X, 16'($urandom));
        write_reg(REG_SCALE_Y, (sel < 10) ? 16'd4096 : 16'($urandom));
        write_reg(REG_BOX_LIMIT, (sel < 6) ? 16'($urandom_range(0, 5)) : 16'($urandom));
    endtask

    // receiver: bursts of pop, random stalls, one long hold on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                pop <= 1'b0;
                repeat (800) @(posedge i_clk);
                hold_request = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tie between classes, the first maximum wins
        write_reg(REG_CLASS_COUNT, 3);
        send(0, 0); send(0, 0); send(0, 0); send(0, 0); send(1024, 0);
        send(512, 0); send(1024, 0); send(1024, 0); send(7, 1);
        settle();
        // extremes, saturated score and edges
        write_reg(REG_MIN_SCORE, 1024);
        write_reg(REG_SCALE_X, 16'hFFFF);
        write_reg(REG_SCALE_Y, 0);
        write_reg(REG_CLASS_COUNT, 0);
        send(32767, 0); send(-32768, 0); send(32767, 0); send(-32768, 0);
        send(32767, 0); send(32767, 1);
        settle();
        // zero threshold, negative product, box limit of zero
        write_reg(REG_MIN_SCORE, 0);
        write_reg(REG_BOX_LIMIT, 0);
        write_reg(REG_NET_WIDTH, 8);
        write_reg(REG_NET_HEIGHT, 2048);
        send(100, 0); send(-100, 0); send(0, 0); send(0, 0); send(0, 0); send(-5, 0);
        send(1, 0); send(2, 0); send(3, 0); send(4, 0); send(500, 0); send(-9, 0);
        send(1, 0); send(2, 0); send(3, 0); send(4, 0); send(500, 0); send(9, 1);
        settle();
        // long receiver hold while nearly every row is kept
        write_reg(REG_CLASS_COUNT, 3);
        write_reg(REG_MIN_SCORE, 0);
        write_reg(REG_BOX_LIMIT, 16'hFFFF);
        write_reg(REG_NET_WIDTH, 640);
        write_reg(REG_NET_HEIGHT, 640);
        write_reg(REG_SCALE_X, 4096);
        write_reg(REG_SCALE_Y, 4096);
        hold_request = 1;
        run_frame(12, 0);
        run_frame(12, 0);
        settle();

        while (elements_sent < 1600) begin
            random_setup();
            if (elements_sent > 1400) calm = 1;
            repeat ($urandom_range(1, 4)) begin
                if (elements_sent < 1600) begin
                    if ($urandom_range(0, 19) == 0) begin
                        repeat ($urandom_range(1, 30)) send(16'($urandom), 0);
                        send(16'($urandom), 1);
                    end else begin
                        run_frame($urandom_range(1, 12), $urandom_range(0, 9) == 0);
                    end
                end
            end
            settle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
sv/afd_pkg.sv
sv/afd_fifo.sv
sv/afd_front.sv
sv/afd_back.sv
sv/anchor_free_detection_decode.sv
bench/afd_box_checker.sv
bench/anchor_free_detection_decode_test.sv
